// ----- sv/dnsarp_pkg.sv -----
// Shared types and constants for the DNS response A-record parser.
package dnsarp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_QNAME,
        PH_QTAIL,
        PH_ANSWER,
        PH_RDATA,
        PH_DONE
    } parse_phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_A      = 2'd1,
        KIND_SKIP   = 2'd2
    } result_kind_t;

    localparam logic [15:0] HEADER_LAST  = 16'd11;
    localparam logic [15:0] QTAIL_LAST   = 16'd3;
    localparam logic [15:0] ANSWER_LAST  = 16'd11;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] A_RDATA_LEN  = 16'd4;

    localparam logic [15:0] IDX_TID_HI   = 16'd0;
    localparam logic [15:0] IDX_TID_LO   = 16'd1;
    localparam logic [15:0] IDX_ANC_HI   = 16'd6;
    localparam logic [15:0] IDX_ANC_LO   = 16'd7;
    localparam logic [15:0] IDX_TYPE_HI  = 16'd2;
    localparam logic [15:0] IDX_TYPE_LO  = 16'd3;
    localparam logic [15:0] IDX_RDLEN_HI = 16'd10;
    localparam logic [15:0] IDX_RDLEN_LO = 16'd11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } msg_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] transaction_id;
        logic [15:0] answer_count;
        logic [15:0] record_type;
        logic [31:0] ipv4_address;
        logic        last_result;
    } res_t;

endpackage

// ----- sv/dns_response_a_record_parser_core.sv -----
// DNS response parser: one message byte per transfer, header, A-record and skipped-record results out.
// Takes one byte per cycle with no gaps required: each byte is captured in an input
// register and parsed from there once the result register can advance, and each result
// it yields is captured in the result register. Throughput is one byte per cycle,
// limited only by the result register: msg_stall rises only while a finished result
// is held by res_stall and the input register is full.
module dns_response_a_record_parser_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              msg_valid,
    output logic              msg_stall,
    input  dnsarp_pkg::msg_t  msg_data,
    output logic              res_valid,
    input  logic              res_stall,
    output dnsarp_pkg::res_t  res_data
);
    import dnsarp_pkg::*;

    logic         in_valid_reg;
    msg_t         in_data_reg;
    logic         res_valid_reg;
    res_t         res_data_reg;

    parse_phase_t phase_reg,  phase_next;
    logic [15:0]  fbc_reg,    fbc_next;
    logic [7:0]   skip_reg,   skip_next;
    logic [15:0]  tid_reg,    tid_next;
    logic [15:0]  anc_reg,    anc_next;
    logic [15:0]  left_reg,   left_next;
    logic [15:0]  type_reg,   type_next;
    logic [15:0]  rdlen_reg,  rdlen_next;
    logic [31:0]  addr_reg,   addr_next;

    logic         advance;
    logic         go;
    logic         emit;
    res_t         result;

    assign advance   = ~res_valid_reg | ~res_stall;
    assign go        = in_valid_reg & advance;
    assign msg_stall = in_valid_reg & ~advance;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] idx;
        logic        finish;
        logic        is_a;
        logic        last;

        b          = in_data_reg.data_byte;
        idx        = fbc_reg;
        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        skip_next  = skip_reg;
        tid_next   = tid_reg;
        anc_next   = anc_reg;
        left_next  = left_reg;
        type_next  = type_reg;
        rdlen_next = rdlen_reg;
        addr_next  = addr_reg;
        emit       = 1'b0;
        finish     = 1'b0;
        is_a       = 1'b0;
        last       = 1'b0;
        result     = '0;

        if (go)
        begin
            if (in_data_reg.packet_start)
            begin
                phase_next = PH_HEADER;
                fbc_next   = '0;
                skip_next  = '0;
                tid_next   = '0;
                anc_next   = '0;
                left_next  = '0;
                type_next  = '0;
                rdlen_next = '0;
                addr_next  = '0;
            end

            idx = fbc_next;
            case (phase_next)
                PH_HEADER:
                begin
                    if (idx == IDX_TID_HI || idx == IDX_TID_LO)
                        tid_next = {tid_next[7:0], b};
                    else if (idx == IDX_ANC_HI || idx == IDX_ANC_LO)
                        anc_next = {anc_next[7:0], b};
                    if (idx >= HEADER_LAST)
                    begin
                        phase_next = PH_QNAME;
                        fbc_next   = '0;
                        skip_next  = '0;
                    end
                    else
                    begin
                        fbc_next = idx + 16'd1;
                    end
                end
                PH_QNAME:
                begin
                    if (skip_next != 8'd0)
                        skip_next = skip_next - 8'd1;
                    else if (b == 8'd0)
                    begin
                        phase_next = PH_QTAIL;
                        fbc_next   = '0;
                    end
                    else
                        skip_next = b;
                end
                PH_QTAIL:
                begin
                    if (idx < QTAIL_LAST)
                        fbc_next = idx + 16'd1;
                    else
                    begin
                        left_next  = anc_next;
                        fbc_next   = '0;
                        last       = (anc_next == 16'd0);
                        phase_next = last ? PH_DONE : PH_ANSWER;
                        emit       = 1'b1;
                        result.result_kind = KIND_HEADER;
                        result.last_result = last;
                    end
                end
                PH_ANSWER:
                begin
                    if (idx == IDX_TYPE_HI || idx == IDX_TYPE_LO)
                        type_next = {type_next[7:0], b};
                    else if (idx == IDX_RDLEN_HI || idx == IDX_RDLEN_LO)
                        rdlen_next = {rdlen_next[7:0], b};
                    if (idx < ANSWER_LAST)
                    begin
                        if (idx == 16'd0)
                        begin
                            type_next  = '0;
                            rdlen_next = '0;
                        end
                        fbc_next = idx + 16'd1;
                    end
                    else
                    begin
                        addr_next = '0;
                        fbc_next  = '0;
                        if (rdlen_next == 16'd0)
                            finish = 1'b1;
                        else
                            phase_next = PH_RDATA;
                    end
                end
                PH_RDATA:
                begin
                    if (idx < A_RDATA_LEN)
                        addr_next = {addr_next[23:0], b};
                    if (({1'b0, idx} + 17'd1) >= {1'b0, rdlen_next})
                        finish = 1'b1;
                    else
                        fbc_next = idx + 16'd1;
                end
                default:
                begin
                end
            endcase

            if (finish)
            begin
                is_a       = (type_next == TYPE_A) && (rdlen_next == A_RDATA_LEN);
                left_next  = left_next - 16'd1;
                last       = (left_next == 16'd0);
                fbc_next   = '0;
                phase_next = last ? PH_DONE : PH_ANSWER;
                emit       = 1'b1;
                result.result_kind  = is_a ? KIND_A : KIND_SKIP;
                result.record_type  = type_next;
                result.ipv4_address = is_a ? addr_next : 32'd0;
                result.last_result  = last;
            end

            result.transaction_id = tid_next;
            result.answer_count   = anc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            fbc_reg       <= '0;
            skip_reg      <= '0;
            tid_reg       <= '0;
            anc_reg       <= '0;
            left_reg      <= '0;
            type_reg      <= '0;
            rdlen_reg     <= '0;
            addr_reg      <= '0;
        end
        else
        begin
            if (!msg_stall)
                in_valid_reg <= msg_valid;
            if (advance)
                res_valid_reg <= go & emit;
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            skip_reg  <= skip_next;
            tid_reg   <= tid_next;
            anc_reg   <= anc_next;
            left_reg  <= left_next;
            type_reg  <= type_next;
            rdlen_reg <= rdlen_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_valid && !msg_stall)
            in_data_reg <= msg_data;
        if (go && emit)
            res_data_reg <= result;
    end

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the DNS response A-record parser core.
`timescale 1ns / 100ps

module tb;
    import dnsarp_pkg::*;

    logic clk;
    logic rst_n = 1'b0;
    logic msg_valid = 1'b0;
    logic msg_stall;
    msg_t msg_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    dns_response_a_record_parser_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_data  (msg_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    msg_t        bytes_to_send[$];
    res_t        dns_results_due[$];
    logic [7:0]  resp_bytes[$];

    int  send_idle_pct = 23;
    int  recv_stall_pct = 77;
    int  run_phase = 0;
    int  total_queued = 0;
    int  bytes_accepted = 0;
    int  parsed_bytes = 0;
    int  phase_bytes = 0;
    int  responses_sent = 0;
    int  mismatches = 0;
    int  header_seen = 0;
    int  a_seen = 0;
    int  skip_seen = 0;
    bit  long_rdata_done = 1'b0;
    logic msg_sent = 1'b0;

    parse_phase_t parse_state = PH_IDLE;
    logic [15:0]  field_idx = '0;
    logic [7:0]   label_left = '0;
    logic [15:0]  txn_id = '0;
    logic [15:0]  ans_count = '0;
    logic [15:0]  ans_left = '0;
    logic [15:0]  rec_type = '0;
    logic [15:0]  rd_len = '0;
    logic [31:0]  addr_acc = '0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic res_t finish_answer();
        res_t r;
        bit   is_a;
        is_a = (rec_type == TYPE_A) && (rd_len == A_RDATA_LEN);
        ans_left = ans_left - 16'd1;
        r.result_kind    = is_a ? KIND_A : KIND_SKIP;
        r.transaction_id = txn_id;
        r.answer_count   = ans_count;
        r.record_type    = rec_type;
        r.ipv4_address   = is_a ? addr_acc : 32'd0;
        r.last_result    = (ans_left == 16'd0);
        field_idx = '0;
        parse_state = (ans_left == 16'd0) ? PH_DONE : PH_ANSWER;
        return r;
    endfunction

    function automatic bit parse_dns_byte(input msg_t m, output res_t r);
        logic [15:0] idx;
        logic [7:0]  b;
        bit          emit;
        emit = 1'b0;
        r = '0;
        b = m.data_byte;
        if (m.packet_start)
        begin
            parse_state = PH_HEADER;
            field_idx = '0;
            label_left = '0;
            txn_id = '0;
            ans_count = '0;
            ans_left = '0;
            rec_type = '0;
            rd_len = '0;
            addr_acc = '0;
        end
        idx = field_idx;
        case (parse_state)
            PH_HEADER:
            begin
                if (idx == IDX_TID_HI || idx == IDX_TID_LO)
                    txn_id = {txn_id[7:0], b};
                else if (idx == IDX_ANC_HI || idx == IDX_ANC_LO)
                    ans_count = {ans_count[7:0], b};
                if (idx == HEADER_LAST)
                begin
                    parse_state = PH_QNAME;
                    field_idx = '0;
                    label_left = '0;
                end
                else
                    field_idx = idx + 16'd1;
            end
            PH_QNAME:
            begin
                if (label_left != 8'd0)
                    label_left = label_left - 8'd1;
                else if (b == 8'd0)
                begin
                    parse_state = PH_QTAIL;
                    field_idx = '0;
                end
                else
                    label_left = b;
            end
            PH_QTAIL:
            begin
                if (idx != QTAIL_LAST)
                    field_idx = idx + 16'd1;
                else
                begin
                    ans_left = ans_count;
                    field_idx = '0;
                    parse_state = (ans_left == 16'd0) ? PH_DONE : PH_ANSWER;
                    r.result_kind    = KIND_HEADER;
                    r.transaction_id = txn_id;
                    r.answer_count   = ans_count;
                    r.last_result    = (ans_left == 16'd0);
                    emit = 1'b1;
                end
            end
            PH_ANSWER:
            begin
                if (idx == IDX_TYPE_HI || idx == IDX_TYPE_LO)
                    rec_type = {rec_type[7:0], b};
                else if (idx == IDX_RDLEN_HI || idx == IDX_RDLEN_LO)
                    rd_len = {rd_len[7:0], b};
                if (idx != ANSWER_LAST)
                begin
                    if (idx == 16'd0)
                    begin
                        rec_type = '0;
                        rd_len = '0;
                    end
                    field_idx = idx + 16'd1;
                end
                else
                begin
                    addr_acc = '0;
                    field_idx = '0;
                    if (rd_len == 16'd0)
                    begin
                        r = finish_answer();
                        emit = 1'b1;
                    end
                    else
                        parse_state = PH_RDATA;
                end
            end
            PH_RDATA:
            begin
                if (idx < A_RDATA_LEN)
                    addr_acc = {addr_acc[23:0], b};
                if (int'(idx) + 1 >= int'(rd_len))
                begin
                    r = finish_answer();
                    emit = 1'b1;
                end
                else
                    field_idx = idx + 16'd1;
            end
            default:
            begin
            end
        endcase
        return emit;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic start, input bit counted);
        msg_t m;
        m.data_byte = b;
        m.packet_start = start;
        bytes_to_send.push_back(m);
        total_queued++;
        if (counted)
        begin
            parsed_bytes++;
            phase_bytes++;
        end
    endtask

    task automatic add_rand(input int n);
        repeat (n) resp_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_word(input logic [15:0] w);
        resp_bytes.push_back(w[15:8]);
        resp_bytes.push_back(w[7:0]);
    endtask

    task automatic queue_response();
        int          n_ans;
        int          lbl;
        bit          big;
        bit          cut_short;
        logic [15:0] anc;
        logic [15:0] rtype;
        logic [15:0] rdlen;
        resp_bytes.delete();
        cut_short = 1'b0;
        big = ($urandom_range(0, 11) == 0);
        n_ans = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
        if (big)
        begin
            anc = 16'($urandom_range(256, 65535));
            n_ans = $urandom_range(1, 3);
        end
        else
            anc = 16'(n_ans);
        add_word(16'($urandom));
        add_rand(4);
        add_word(anc);
        add_rand(4);
        repeat ($urandom_range(0, 3))
        begin
            lbl = ($urandom_range(0, 14) == 0) ? $urandom_range(192, 255) : $urandom_range(1, 6);
            resp_bytes.push_back(8'(lbl));
            add_rand(lbl);
        end
        resp_bytes.push_back(8'd0);
        add_rand(4);
        for (int i = 0; i < n_ans; i++)
        begin
            resp_bytes.push_back({2'b11, 6'($urandom_range(0, 63))});
            add_rand(1);
            case ($urandom_range(0, 9))
                7: rtype = 16'd28;
                8, 9: rtype = 16'($urandom);
                default: rtype = TYPE_A;
            endcase
            add_word(rtype);
            add_rand(6);
            case ($urandom_range(0, 11))
                0: rdlen = 16'd0;
                1, 2: rdlen = 16'($urandom_range(1, 8));
                3:
                begin
                    if (run_phase == 2 && !long_rdata_done)
                    begin
                        rdlen = 16'h0123;
                        long_rdata_done = 1'b1;
                    end
                    else
                    begin
                        rdlen = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
                        cut_short = 1'b1;
                    end
                end
                default: rdlen = A_RDATA_LEN;
            endcase
            add_word(rdlen);
            if (cut_short)
            begin
                add_rand($urandom_range(0, 20));
                break;
            end
            add_rand(int'(rdlen));
        end
        foreach (resp_bytes[i]) push_byte(resp_bytes[i], i == 0, 1'b1);
        if (!big && !cut_short && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        responses_sent++;
    endtask

    task automatic queue_noise();
        int n;
        n = $urandom_range(4, 40);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 15) == 0, 1'b1);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            msg_valid <= 1'b0;
        else if (!msg_valid || msg_sent)
        begin
            if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                msg_data <= bytes_to_send.pop_front();
                msg_valid <= 1'b1;
            end
            else
                msg_valid <= 1'b0;
        end
        res_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        res_t r;
        msg_sent <= rst_n && msg_valid && !msg_stall;
        if (rst_n && msg_valid && !msg_stall)
        begin
            bytes_accepted++;
            if (parse_dns_byte(msg_data, r))
                dns_results_due.push_back(r);
        end
    end

    always @(posedge clk)
    begin
        res_t due;
        if (rst_n && res_valid && !res_stall)
        begin
            case (res_data.result_kind)
                KIND_HEADER: header_seen++;
                KIND_A: a_seen++;
                default: skip_seen++;
            endcase
            if (dns_results_due.size() == 0)
            begin
                $error("unexpected result: kind %0d, transaction_id %h",
                       res_data.result_kind, res_data.transaction_id);
                mismatches++;
            end
            else
            begin
                due = dns_results_due.pop_front();
                if (res_data.result_kind !== due.result_kind)
                begin
                    $error("result_kind: expected %0d, got %0d",
                           due.result_kind, res_data.result_kind);
                    mismatches++;
                end
                if (res_data.transaction_id !== due.transaction_id)
                begin
                    $error("transaction_id: expected %h, got %h",
                           due.transaction_id, res_data.transaction_id);
                    mismatches++;
                end
                if (res_data.answer_count !== due.answer_count)
                begin
                    $error("answer_count: expected %h, got %h",
                           due.answer_count, res_data.answer_count);
                    mismatches++;
                end
                if (res_data.record_type !== due.record_type)
                begin
                    $error("record_type: expected %h, got %h",
                           due.record_type, res_data.record_type);
                    mismatches++;
                end
                if (res_data.ipv4_address !== due.ipv4_address)
                begin
                    $error("ipv4_address: expected %h, got %h",
                           due.ipv4_address, res_data.ipv4_address);
                    mismatches++;
                end
                if (res_data.last_result !== due.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           due.last_result, res_data.last_result);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("dns_response_a_record_parser_core verification failed");
        $finish;
    end

    initial
    begin
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        resp_bytes.delete();
        add_word(16'hFFFF);
        add_rand(4);
        add_word(16'h0000);
        add_rand(4);
        resp_bytes.push_back(8'h00);
        add_word(16'hFFFF);
        add_word(16'h0000);
        foreach (resp_bytes[i]) push_byte(resp_bytes[i], i == 0, 1'b1);
        push_byte(8'hAB, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'h5A, 1'b0, 1'b1);

        for (int p = 0; p < 3; p++)
        begin
            run_phase = p;
            send_idle_pct = (p == 0) ? 23 : (p == 1) ? 77 : 0;
            recv_stall_pct = (p == 0) ? 77 : (p == 1) ? 23 : 0;
            while (phase_bytes < 300)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_noise();
                else
                    queue_response();
            end
            phase_bytes = 0;
            if (p == 0)
            begin
                repeat (8) @(posedge clk);
                @(negedge clk);
                rst_n = 1'b1;
            end
            while (bytes_accepted != total_queued || dns_results_due.size() != 0)
                @(posedge clk);
        end
        repeat (16) @(posedge clk);

        $display("covered %0d parsed bytes in %0d responses plus noise bursts", parsed_bytes,
                 responses_sent);
        $display("results checked: %0d header, %0d A record, %0d skipped", header_seen, a_seen,
                 skip_seen);
        if (mismatches == 0)
            $display("dns_response_a_record_parser_core verification clean");
        else
            $display("dns_response_a_record_parser_core verification failed");
        $finish;
    end

endmodule

// ----- dns_response_a_record_parser_core.f -----
sv/dnsarp_pkg.sv
sv/dns_response_a_record_parser_core.sv
bench/tb.sv
